FILE: design/dgn_pkg.sv
// Shared types and constants for the depth gradient normal pipeline.
package dgn_pkg;

  localparam int unsigned MaxDimDefault = 4096;
  localparam int unsigned MagW          = 30;
  localparam int unsigned SqrtSteps     = 31;
  localparam int unsigned DivSteps      = 16;
  localparam int unsigned CfgW          = 24;

  typedef enum logic [2:0] {
    CfgFocalX      = 3'd0,
    CfgFocalY      = 3'd1,
    CfgCenterX     = 3'd2,
    CfgCenterY     = 3'd3,
    CfgImageWidth  = 3'd4,
    CfgImageHeight = 3'd5
  } cfg_idx_e;

  typedef logic [2:0][MagW-1:0] dgn_mag_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  neg;
    logic [31:0] depth;
  } dgn_side_t;

endpackage

FILE: design/dgn_front.sv
// Front end: border tests, differences, products, scaling and sum of squares.
module dgn_front import dgn_pkg::*; #(
  parameter int unsigned MaxDim = MaxDimDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        in_v_i,
  input  logic [11:0] col_i,
  input  logic [11:0] row_i,
  input  logic [31:0] zc_i,
  input  logic [31:0] zl_i,
  input  logic [31:0] zr_i,
  input  logic [31:0] zt_i,
  input  logic [31:0] zb_i,
  input  logic [23:0] fx_i,
  input  logic [23:0] fy_i,
  input  logic [23:0] cx_i,
  input  logic [23:0] cy_i,
  input  logic [12:0] width_i,
  input  logic [12:0] height_i,
  output logic        v_o,
  output logic [61:0] sum_o,
  output dgn_mag_t    a_o,
  output dgn_side_t   side_o
);

  localparam logic [16:0] MaxD = 17'(MaxDim);

  // stage 1
  logic [16:0] wc, hc, colp1, rowp1;
  logic        ok1_d;
  logic signed [32:0] d1_d, e1_d, d1_q, e1_q;
  logic signed [24:0] cxd1_d, cyd1_d, cxd1_q, cyd1_q;
  logic [31:0] dmag1_q, emag1_q, zc1_q;
  logic        dneg1_q, eneg1_q, ok1_q, v1_q;

  always_comb begin
    wc     = ({4'b0, width_i} > MaxD) ? MaxD : {4'b0, width_i};
    hc     = ({4'b0, height_i} > MaxD) ? MaxD : {4'b0, height_i};
    colp1  = {5'b0, col_i} + 17'd1;
    rowp1  = {5'b0, row_i} + 17'd1;
    ok1_d  = !(col_i == 12'd0 || row_i == 12'd0 || colp1 >= wc || rowp1 >= hc) &&
             !(zc_i == 32'd0 || zl_i == 32'd0 || zr_i == 32'd0 ||
               zt_i == 32'd0 || zb_i == 32'd0);
    d1_d   = $signed({1'b0, zr_i}) - $signed({1'b0, zl_i});
    e1_d   = $signed({1'b0, zb_i}) - $signed({1'b0, zt_i});
    cxd1_d = $signed({1'b0, cx_i}) - $signed({5'b0, col_i, 8'b0});
    cyd1_d = $signed({1'b0, cy_i}) - $signed({5'b0, row_i, 8'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q    <= d1_d;
      e1_q    <= e1_d;
      dneg1_q <= d1_d[32];
      eneg1_q <= e1_d[32];
      dmag1_q <= d1_d[32] ? 32'(-d1_d) : d1_d[31:0];
      emag1_q <= e1_d[32] ? 32'(-e1_d) : e1_d[31:0];
      cxd1_q  <= cxd1_d;
      cyd1_q  <= cyd1_d;
      zc1_q   <= zc_i;
      ok1_q   <= ok1_d;
    end
  end

  // stage 2: products
  logic [55:0] pnx2_q, pny2_q;
  logic signed [57:0] pdz2_d, pez2_d, pdz2_q, pez2_q;
  logic        negx2_q, negy2_q, ok2_q, v2_q;
  logic [31:0] zc2_q;

  assign pdz2_d = cxd1_q * d1_q;
  assign pez2_d = cyd1_q * e1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pnx2_q  <= fx_i * dmag1_q;
      pny2_q  <= fy_i * emag1_q;
      pdz2_q  <= pdz2_d;
      pez2_q  <= pez2_d;
      negx2_q <= dneg1_q;
      negy2_q <= eneg1_q;
      zc2_q   <= zc1_q;
      ok2_q   <= ok1_q;
    end
  end

  // stage 3: z component
  logic signed [59:0] nz3_d;
  logic [58:0] mz3_q;
  logic [55:0] mx3_q, my3_q;
  logic [2:0]  neg3_q;
  logic [31:0] zc3_q;
  logic        ok3_q, v3_q;

  assign nz3_d = 60'(pdz2_q) + 60'(pez2_q) - $signed({19'b0, zc2_q, 9'b0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx3_q  <= pnx2_q;
      my3_q  <= pny2_q;
      mz3_q  <= nz3_d[59] ? 59'(-nz3_d) : nz3_d[58:0];
      neg3_q <= {nz3_d[59], negy2_q, negx2_q};
      zc3_q  <= zc2_q;
      ok3_q  <= ok2_q;
    end
  end

  // stage 4: short test and shift amount
  logic [58:0] mor;
  logic [4:0]  sh4_d, sh4_q;
  logic [13:0] sq_small;
  logic        short4;
  logic [58:0] mx4_q, my4_q, mz4_q;
  logic [2:0]  neg4_q;
  logic [31:0] zc4_q;
  logic        ok4_q, v4_q;

  always_comb begin
    mor   = {3'b0, mx3_q} | {3'b0, my3_q} | mz3_q;
    sh4_d = 5'd0;
    for (int i = MagW; i < 59; i++) begin
      if (mor[i]) sh4_d = 5'(i - (MagW - 1));
    end
    sq_small = 14'(mx3_q[5:0] * mx3_q[5:0]) + 14'(my3_q[5:0] * my3_q[5:0]) +
               14'(mz3_q[5:0] * mz3_q[5:0]);
    short4 = (mx3_q < 56'd34) && (my3_q < 56'd34) && (mz3_q < 59'd34) &&
             (sq_small <= 14'd1125);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx4_q  <= {3'b0, mx3_q};
      my4_q  <= {3'b0, my3_q};
      mz4_q  <= mz3_q;
      sh4_q  <= sh4_d;
      neg4_q <= neg3_q;
      zc4_q  <= zc3_q;
      ok4_q  <= ok3_q && !short4;
    end
  end

  // stage 5: normalise
  dgn_mag_t   a5_q;
  dgn_side_t  side5_q;
  logic       v5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a5_q[0] <= MagW'(mx4_q >> sh4_q);
      a5_q[1] <= MagW'(my4_q >> sh4_q);
      a5_q[2] <= MagW'(mz4_q >> sh4_q);
      side5_q <= '{ok: ok4_q, neg: neg4_q, depth: zc4_q};
    end
  end

  // stage 6: squares
  logic [2:0][59:0] sq6_q;
  dgn_mag_t   a6_q;
  dgn_side_t  side6_q;
  logic       v6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) sq6_q[k] <= a5_q[k] * a5_q[k];
      a6_q    <= a5_q;
      side6_q <= side5_q;
    end
  end

  // stage 7: sum
  logic [61:0] sum7_q;
  dgn_mag_t   a7_q;
  dgn_side_t  side7_q;
  logic       v7_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum7_q  <= 62'(sq6_q[0]) + 62'(sq6_q[1]) + 62'(sq6_q[2]);
      a7_q    <= a6_q;
      side7_q <= side6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_v_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  assign v_o    = v7_q;
  assign sum_o  = sum7_q;
  assign a_o    = a7_q;
  assign side_o = side7_q;

endmodule

FILE: design/dgn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module dgn_sqrt import dgn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        in_v_i,
  input  logic [61:0] sum_i,
  input  dgn_mag_t    a_i,
  input  dgn_side_t   side_i,
  output logic        v_o,
  output logic [30:0] root_o,
  output dgn_mag_t    a_o,
  output dgn_side_t   side_o
);

  logic [62:0] rem_q  [SqrtSteps];
  logic [62:0] root_q [SqrtSteps];
  dgn_mag_t    a_q    [SqrtSteps];
  dgn_side_t   side_q [SqrtSteps];
  logic        v_q    [SqrtSteps];

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
    localparam logic [62:0] Bit = 63'd1 << (2 * (SqrtSteps - 1 - i));
    logic [62:0] rem_in, root_in, trial;
    dgn_mag_t    a_in;
    dgn_side_t   side_in;
    logic        v_in;

    if (i == 0) begin : g_first
      assign rem_in  = {1'b0, sum_i};
      assign root_in = '0;
      assign a_in    = a_i;
      assign side_in = side_i;
      assign v_in    = in_v_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign a_in    = a_q[i-1];
      assign side_in = side_q[i-1];
      assign v_in    = v_q[i-1];
    end

    assign trial = root_in + Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[i]  <= rem_in - trial;
          root_q[i] <= (root_in >> 1) + Bit;
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= root_in >> 1;
        end
        a_q[i]    <= a_in;
        side_q[i] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end
  end

  assign v_o    = v_q[SqrtSteps-1];
  assign root_o = root_q[SqrtSteps-1][30:0];
  assign a_o    = a_q[SqrtSteps-1];
  assign side_o = side_q[SqrtSteps-1];

endmodule

FILE: design/dgn_div.sv
// Pipelined rounded division of three magnitudes by the length, one bit per stage.
module dgn_div import dgn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_v_i,
  input  logic [30:0]      root_i,
  input  dgn_mag_t         a_i,
  input  dgn_side_t        side_i,
  output logic             v_o,
  output logic [2:0][15:0] quo_o,
  output dgn_side_t        side_o
);

  logic [2:0][30:0] rem_q  [DivSteps+1];
  logic [2:0][15:0] nq_q   [DivSteps+1];
  logic [30:0]      root_q [DivSteps+1];
  dgn_side_t        side_q [DivSteps+1];
  logic             v_q    [DivSteps+1];

  // stage 0: numerator a*2^15 + r/2, top bits as first partial remainder
  logic [2:0][45:0] num;
  always_comb begin
    for (int k = 0; k < 3; k++) num[k] = {a_i[k], 15'b0} + {15'b0, 1'b0, root_i[30:1]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        rem_q[0][k] <= {1'b0, num[k][45:16]};
        nq_q[0][k]  <= num[k][15:0];
      end
      root_q[0] <= root_i;
      side_q[0] <= '{ok: side_i.ok && (root_i != 31'd0), neg: side_i.neg,
                     depth: side_i.depth};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= in_v_i;
    end
  end

  for (genvar j = 1; j <= DivSteps; j++) begin : g_step
    logic [2:0][31:0] trial;
    always_comb begin
      for (int k = 0; k < 3; k++) trial[k] = {rem_q[j-1][k], nq_q[j-1][k][15]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < 3; k++) begin
          if (trial[k] >= {1'b0, root_q[j-1]}) begin
            rem_q[j][k] <= 31'(trial[k] - {1'b0, root_q[j-1]});
            nq_q[j][k]  <= {nq_q[j-1][k][14:0], 1'b1};
          end else begin
            rem_q[j][k] <= trial[k][30:0];
            nq_q[j][k]  <= {nq_q[j-1][k][14:0], 1'b0};
          end
        end
        root_q[j] <= root_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_q[j-1];
      end
    end
  end

  assign v_o    = v_q[DivSteps];
  assign quo_o  = nq_q[DivSteps];
  assign side_o = side_q[DivSteps];

endmodule

FILE: design/depth_gradient_normal.sv
// Top level: unit surface normal from a depth stencil, fully pipelined.
// Input transfer to result passes 7 front-end stages, 31 square root stages,
// 17 divider stages and the output register. Throughput one item per cycle;
// the whole pipeline holds while a result waits. Reset clears all valid bits,
// zeroes the focal and centre registers and sets width and height to 4096.
module depth_gradient_normal import dgn_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [11:0]        col_i,
  input  logic [11:0]        row_i,
  input  logic [31:0]        depth_center_i,
  input  logic [31:0]        depth_left_i,
  input  logic [31:0]        depth_right_i,
  input  logic [31:0]        depth_top_i,
  input  logic [31:0]        depth_bottom_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic [31:0]        depth_out_o,
  output logic               valid_res_o
);

  logic [23:0] fx_q, fy_q, cx_q, cy_q;
  logic [12:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q     <= '0;
      fy_q     <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      width_q  <= 13'd4096;
      height_q <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgFocalX:      fx_q     <= cfg_data_i[23:0];
        CfgFocalY:      fy_q     <= cfg_data_i[23:0];
        CfgCenterX:     cx_q     <= cfg_data_i[23:0];
        CfgCenterY:     cy_q     <= cfg_data_i[23:0];
        CfgImageWidth:  width_q  <= cfg_data_i[12:0];
        CfgImageHeight: height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v_q;
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  logic        fr_v;
  logic [61:0] fr_sum;
  dgn_mag_t    fr_a;
  dgn_side_t   fr_side;

  dgn_front #(.MaxDim(MAX_DIM)) u_front (
    .clk_i, .rst_ni, .en_i(en), .in_v_i(in_valid_i),
    .col_i, .row_i,
    .zc_i(depth_center_i), .zl_i(depth_left_i), .zr_i(depth_right_i),
    .zt_i(depth_top_i), .zb_i(depth_bottom_i),
    .fx_i(fx_q), .fy_i(fy_q), .cx_i(cx_q), .cy_i(cy_q),
    .width_i(width_q), .height_i(height_q),
    .v_o(fr_v), .sum_o(fr_sum), .a_o(fr_a), .side_o(fr_side)
  );

  logic        sq_v;
  logic [30:0] sq_root;
  dgn_mag_t    sq_a;
  dgn_side_t   sq_side;

  dgn_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .in_v_i(fr_v), .sum_i(fr_sum), .a_i(fr_a),
    .side_i(fr_side), .v_o(sq_v), .root_o(sq_root), .a_o(sq_a), .side_o(sq_side)
  );

  logic             dv_v;
  logic [2:0][15:0] dv_quo;
  dgn_side_t        dv_side;

  dgn_div u_div (
    .clk_i, .rst_ni, .en_i(en), .in_v_i(sq_v), .root_i(sq_root), .a_i(sq_a),
    .side_i(sq_side), .v_o(dv_v), .quo_o(dv_quo), .side_o(dv_side)
  );

  logic [2:0][15:0] comp_d, comp_q;
  logic [31:0]      depth_q;
  logic             ok_q;
  logic [15:0]      sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sat       = dv_quo[k][15] ? 16'h7FFF : dv_quo[k];
      comp_d[k] = !dv_side.ok ? 16'd0 : (dv_side.neg[k] ? 16'(-sat) : sat);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      comp_q  <= comp_d;
      depth_q <= dv_side.ok ? dv_side.depth : 32'd0;
      ok_q    <= dv_side.ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  assign out_valid_o = out_v_q;
  assign normal_x_o  = comp_q[0];
  assign normal_y_o  = comp_q[1];
  assign normal_z_o  = comp_q[2];
  assign depth_out_o = depth_q;
  assign valid_res_o = ok_q;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the depth gradient normal pipeline.
module tb import dgn_pkg::*;;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] zc;
    logic [31:0] zl;
    logic [31:0] zr;
    logic [31:0] zt;
    logic [31:0] zb;
  } stencil_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [31:0]        depth;
    logic               ok;
  } normal_t;

  typedef struct {
    stencil_t px;
    bit       fixed;
    normal_t  res;
  } vec_t;

  localparam int unsigned Latency = 56;
  localparam int unsigned NumRand = 1530;
  localparam longint     Limit   = 600000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_idx_i = '0;
  logic [CfgW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              out_ready_i = 1'b0;
  logic              out_valid_o;
  stencil_t          px_q = '0;
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;
  logic [31:0]       depth_out_o;
  logic              valid_res_o;

  depth_gradient_normal u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .col_i(px_q.col), .row_i(px_q.row), .depth_center_i(px_q.zc),
    .depth_left_i(px_q.zl), .depth_right_i(px_q.zr),
    .depth_top_i(px_q.zt), .depth_bottom_i(px_q.zb),
    .out_valid_o, .out_ready_i,
    .normal_x_o, .normal_y_o, .normal_z_o, .depth_out_o, .valid_res_o
  );

  always #5 clk_i = ~clk_i;

  logic [23:0] fx, fy, cx, cy;
  logic [12:0] img_w, img_h;
  normal_t     normals_pending[$];
  int          n_err = 0;
  bit          quiet = 1'b0;
  bit          hold_off = 1'b0;
  longint      cyc = 0;

  function automatic logic [63:0] isqrt(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] unit_comp(longint n, int sh, logic [63:0] r);
    logic [63:0] a, q;
    a = ((n < 0) ? -n : n) >> sh;
    q = ((a << 15) + (r >> 1)) / r;
    if (q > 32767) q = 32767;
    if (n < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic normal_t surface_normal(stencil_t p);
    normal_t     o;
    longint      w, h, d, e, nx, ny, nz;
    logic [63:0] mx, my, mz, m, r;
    int          sh;
    o = '0;
    w = longint'((img_w > 4096) ? 13'd4096 : img_w);
    h = longint'((img_h > 4096) ? 13'd4096 : img_h);
    if (p.col == 0 || p.row == 0 || p.col + 1 >= w || p.row + 1 >= h) return o;
    if (p.zc == 0 || p.zl == 0 || p.zr == 0 || p.zt == 0 || p.zb == 0) return o;
    d = longint'(p.zr) - longint'(p.zl);
    e = longint'(p.zb) - longint'(p.zt);
    nx = longint'(fx) * d;
    ny = longint'(fy) * e;
    nz = (longint'(cx) - longint'(p.col) * 256) * d
       + (longint'(cy) - longint'(p.row) * 256) * e - longint'(p.zc) * 512;
    mx = (nx < 0) ? -nx : nx;
    my = (ny < 0) ? -ny : ny;
    mz = (nz < 0) ? -nz : nz;
    if (mx < 34 && my < 34 && mz < 34 && mx*mx + my*my + mz*mz <= 1125) return o;
    m = mx;
    if (my > m) m = my;
    if (mz > m) m = mz;
    sh = 0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    mx >>= sh; my >>= sh; mz >>= sh;
    r = isqrt(mx*mx + my*my + mz*mz);
    if (r == 0) return o;
    o.nx = unit_comp(nx, sh, r);
    o.ny = unit_comp(ny, sh, r);
    o.nz = unit_comp(nz, sh, r);
    o.depth = p.zc;
    o.ok = 1'b1;
    return o;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgFocalX:      fx = val;
      CfgFocalY:      fy = val;
      CfgCenterX:     cx = val;
      CfgCenterY:     cy = val;
      CfgImageWidth:  img_w = val[12:0];
      CfgImageHeight: img_h = val[12:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (normals_pending.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic send(stencil_t p, bit fixed, normal_t res);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    normals_pending.insert(normals_pending.size(), fixed ? res : surface_normal(p));
    px_q <= p;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rdepth();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(1, 16);
      2: return 32'h0001_0000 + $urandom_range(0, 4095);
      default: return $urandom | 32'd1;
    endcase
  endfunction

  function automatic stencil_t rand_px(int mode);
    stencil_t    p;
    logic [31:0] base;
    p.col = 12'($urandom_range(1, 4094));
    p.row = 12'($urandom_range(1, 4094));
    if (img_w > 2 && img_w <= 4096) p.col = 12'($urandom_range(1, img_w - 2));
    if (img_h > 2 && img_h <= 4096) p.row = 12'($urandom_range(1, img_h - 2));
    base = rdepth();
    p.zc = base;
    p.zl = base + $urandom_range(0, 2000) - 1000;
    p.zr = base + $urandom_range(0, 2000) - 1000;
    p.zt = base + $urandom_range(0, 2000) - 1000;
    p.zb = base + $urandom_range(0, 2000) - 1000;
    if (mode == 0) begin
      p.col = 12'($urandom);
      p.row = 12'($urandom);
      p.zc = rdepth(); p.zl = rdepth(); p.zr = rdepth(); p.zt = rdepth();
      p.zb = rdepth();
    end else if (mode == 1) begin
      case ($urandom_range(0, 6))
        0: p.col = 0;
        1: p.row = 0;
        2: p.col = 12'hFFF;
        3: p.row = 12'hFFF;
        4: p.zc = 0;
        5: p.zl = 0;
        default: p.zb = 0;
      endcase
    end
    if (p.zl == 0 && mode != 1) p.zl = 1;
    return p;
  endfunction

  // receiver: random stalls, plus one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (4 * Latency) @(negedge clk_i);
        hold_off = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    normal_t got, want;
    cyc <= cyc + 1;
    if (cyc > Limit) begin
      $display("tb: errors");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{normal_x_o, normal_y_o, normal_z_o, depth_out_o, valid_res_o};
      if (normals_pending.size() == 0) begin
        $display("%0t unexpected transfer, actual %p", $time, got);
        n_err++;
      end else begin
        want = normals_pending.pop_front();
        if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
            got.depth !== want.depth || got.ok !== want.ok) begin
          $display("%0t mismatch: expected %p, actual %p", $time, want, got);
          n_err++;
        end
      end
    end
  end

  vec_t dir[$];

  initial begin
    stencil_t p;
    normal_t  z;
    z = '0;
    fx = 0; fy = 0; cx = 0; cy = 0; img_w = 4096; img_h = 4096;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset intrinsics: normal points straight back, (0,0,-1) saturated
    dir.insert(dir.size(),
               '{'{12'd5, 12'd5, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000},
                 1, '{16'sd0, 16'sd0, -16'sd32767, 32'h10000, 1'b1}});
    dir.insert(dir.size(),
               '{'{12'd0, 12'd5, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000},
                 1, z});
    dir.insert(dir.size(),
               '{'{12'd5, 12'd0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000},
                 1, z});
    dir.insert(dir.size(),
               '{'{12'hFFF, 12'd5, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000},
                 1, z});
    dir.insert(dir.size(),
               '{'{12'd5, 12'hFFF, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000},
                 1, z});
    dir.insert(dir.size(), '{'{12'hFFF, 12'hFFF, '1, '1, '1, '1, '1}, 1, z});
    dir.insert(dir.size(),
               '{'{12'd5, 12'd5, 32'd0, 32'h10000, 32'h10000, 32'h10000, 32'h10000}, 1, z});
    dir.insert(dir.size(),
               '{'{12'd5, 12'd5, 32'h10000, 32'd0, 32'h10000, 32'h10000, 32'h10000}, 1, z});
    dir.insert(dir.size(),
               '{'{12'd5, 12'd5, 32'h10000, 32'h10000, 32'd0, 32'h10000, 32'h10000}, 1, z});
    dir.insert(dir.size(),
               '{'{12'd5, 12'd5, 32'h10000, 32'h10000, 32'h10000, 32'd0, 32'h10000}, 1, z});
    dir.insert(dir.size(),
               '{'{12'd5, 12'd5, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'd0}, 1, z});
    // gradient cancels the depth term: short normal
    dir.insert(dir.size(), '{'{12'd2, 12'd5, 32'd1, 32'd2, 32'd1, 32'd1, 32'd1}, 1, z});
    dir.insert(dir.size(),
               '{'{12'd4094, 12'd4094, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'd1}, 0, z});
    dir.insert(dir.size(),
               '{'{12'd1, 12'd1, 32'd3, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF}, 0, z});
    foreach (dir[i]) send(dir[i].px, dir[i].fixed, dir[i].res);
    drain();

    write_reg(CfgFocalX, 24'hFFFFFF);
    write_reg(CfgFocalY, 24'hFFFFFF);
    write_reg(CfgCenterX, 24'hFFFFFF);
    write_reg(CfgCenterY, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) begin
      p = '{12'd7, 12'd9, 32'h10000, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF};
      p.zl = (i & 1) ? 32'd1 : 32'hFFFF_FFFF;
      p.zr = (i & 1) ? 32'hFFFF_FFFF : 32'd1;
      p.zt = (i > 2) ? 32'h20000 : 32'd1;
      send(p, 0, z);
    end
    drain();
    write_reg(CfgImageWidth, 24'd1);
    write_reg(CfgImageHeight, 24'h1FFF);
    send('{12'd5, 12'd5, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000}, 1, z);
    send('{12'd0, 12'd0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000}, 1, z);
    drain();

    for (int k = 0; k < NumRand; k++) begin
      if (k % 150 == 0) begin
        drain();
        case ((k / 150) % 5)
          0: begin
            write_reg(CfgFocalX, 24'($urandom_range(24'h10000, 24'h100000)));
            write_reg(CfgFocalY, 24'($urandom_range(24'h10000, 24'h100000)));
            write_reg(CfgCenterX, 24'($urandom_range(0, 24'h100000)));
            write_reg(CfgCenterY, 24'($urandom_range(0, 24'h100000)));
            write_reg(CfgImageWidth, 24'd4096);
            write_reg(CfgImageHeight, 24'd4096);
          end
          1: begin
            write_reg(CfgFocalX, 24'($urandom));
            write_reg(CfgFocalY, 24'($urandom));
            write_reg(CfgCenterX, 24'($urandom));
            write_reg(CfgCenterY, 24'($urandom));
            write_reg(CfgImageWidth, 24'($urandom_range(0, 24'h1FFF)));
            write_reg(CfgImageHeight, 24'($urandom_range(0, 24'h1FFF)));
          end
          2: begin
            write_reg(CfgFocalX, 24'd0);
            write_reg(CfgFocalY, 24'hFFFFFF);
            write_reg(CfgImageWidth, 24'd3);
            write_reg(CfgImageHeight, 24'd640);
          end
          3: begin
            write_reg(CfgFocalX, 24'($urandom_range(0, 255)));
            write_reg(CfgFocalY, 24'($urandom_range(0, 255)));
            write_reg(CfgImageWidth, 24'd640);
            write_reg(CfgImageHeight, 24'd3);
          end
          default: begin
            write_reg(CfgCenterX, 24'd0);
            write_reg(CfgCenterY, 24'hFFFFFF);
            write_reg(CfgImageWidth, 24'd4097);
            write_reg(CfgImageHeight, 24'd4095);
          end
        endcase
      end
      if (k == 300) hold_off = 1'b1;
      if (k == 700) drain();
      quiet = (k > NumRand - 200);
      p = rand_px($urandom_range(0, 9) < 7 ? 2 : $urandom_range(0, 1));
      send(p, 0, z);
    end

    drain();
    if (n_err == 0 && normals_pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/dgn_pkg.sv
design/dgn_front.sv
design/dgn_sqrt.sv
design/dgn_div.sv
design/depth_gradient_normal.sv
verif/tb.sv
